// File: rtl/nps3d_pkg.sv
// ----------------------------------------------------------------------------
// nps3d_pkg
// Shared types, widths and codes of the 3D nearest point search block.
// ----------------------------------------------------------------------------
package nps3d_pkg;

  localparam int COORD_WIDTH = 30;
  localparam int ID_WIDTH    = 16;
  localparam int DIST_WIDTH  = 31;

  // A square of a coordinate difference and the sum of three squares.
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int SQ_WIDTH    = PROD_WIDTH + 2;

  // Square root: one result bit per step, two radicand bits per step.
  localparam int ROOT_WIDTH  = SQ_WIDTH / 2;
  localparam int REM_WIDTH   = ROOT_WIDTH + 3;
  localparam int ROOT_STEPS  = ROOT_WIDTH;
  localparam int STEP_CNT_W  = $clog2(ROOT_STEPS);

  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;

  typedef logic [AXIS_W-1:0] axis_t;
  localparam axis_t AXIS_LAT = 2'd0;
  localparam axis_t AXIS_LON = 2'd1;
  localparam axis_t AXIS_ALT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_REF_LAT = 2'd0;
  localparam cfg_idx_t REG_REF_LON = 2'd1;
  localparam cfg_idx_t REG_REF_ALT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CMP,
    ST_ROOT,
    ST_DONE
  } state_e;

endpackage

// File: rtl/nps3d_sq_unit.sv
// ----------------------------------------------------------------------------
// nps3d_sq_unit
// Shared squaring unit: registered |a - b|, then its registered square.
// ----------------------------------------------------------------------------
module nps3d_sq_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   issue_i,
  input  logic signed [nps3d_pkg::COORD_WIDTH-1:0] a_i,
  input  logic signed [nps3d_pkg::COORD_WIDTH-1:0] b_i,
  output logic                                   prod_valid_o,
  output logic [nps3d_pkg::PROD_WIDTH-1:0]       prod_o
);

  logic signed [nps3d_pkg::COORD_WIDTH:0] diff;
  logic [nps3d_pkg::COORD_WIDTH:0]        diff_abs;
  logic [nps3d_pkg::COORD_WIDTH-1:0]      mag_d, mag_q;
  logic                                   mag_vld_q;
  logic [nps3d_pkg::PROD_WIDTH-1:0]       prod_q;
  logic                                   prod_vld_q;

  always_comb begin
    diff     = (nps3d_pkg::COORD_WIDTH+1)'(a_i) - (nps3d_pkg::COORD_WIDTH+1)'(b_i);
    diff_abs = diff[nps3d_pkg::COORD_WIDTH] ? (~diff + 1'b1) : diff;
    // The magnitude never reaches 2^COORD_WIDTH, so the top bit is always zero.
    mag_d    = diff_abs[nps3d_pkg::COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      mag_vld_q  <= issue_i;
      prod_vld_q <= mag_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      mag_q <= mag_d;
    end
    if (mag_vld_q) begin
      prod_q <= nps3d_pkg::PROD_WIDTH'(mag_q) * nps3d_pkg::PROD_WIDTH'(mag_q);
    end
  end

  assign prod_valid_o = prod_vld_q;
  assign prod_o       = prod_q;

endmodule

// File: rtl/nps3d_isqrt.sv
// ----------------------------------------------------------------------------
// nps3d_isqrt
// Iterative floor square root, one result bit per clock cycle.
// ----------------------------------------------------------------------------
module nps3d_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nps3d_pkg::SQ_WIDTH-1:0]    radicand_i,
  output logic                              done_o,
  output logic [nps3d_pkg::ROOT_WIDTH-1:0]  root_o
);

  logic                               active_q;
  logic                               done_q;
  logic [nps3d_pkg::STEP_CNT_W-1:0]   cnt_q;
  logic [nps3d_pkg::SQ_WIDTH-1:0]     x_q;
  logic [nps3d_pkg::REM_WIDTH-1:0]    rem_q;
  logic [nps3d_pkg::ROOT_WIDTH-1:0]   root_q;

  logic [nps3d_pkg::REM_WIDTH-1:0]    rem_sh;
  logic [nps3d_pkg::REM_WIDTH-1:0]    trial;
  logic                               fits;
  logic                               last_step;

  always_comb begin
    // Bring down the next two radicand bits and try the root bit as a one.
    rem_sh    = {rem_q[nps3d_pkg::REM_WIDTH-3:0],
                 x_q[nps3d_pkg::SQ_WIDTH-1:nps3d_pkg::SQ_WIDTH-2]};
    trial     = nps3d_pkg::REM_WIDTH'({root_q, 2'b01});
    fits      = (rem_sh >= trial);
    last_step = (cnt_q == nps3d_pkg::STEP_CNT_W'(nps3d_pkg::ROOT_STEPS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (active_q) begin
      x_q    <= {x_q[nps3d_pkg::SQ_WIDTH-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[nps3d_pkg::ROOT_WIDTH-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/nearest_point_search_3d.sv
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Finds the candidate point nearest to a configured reference point.
// ----------------------------------------------------------------------------
// Candidates arrive on the input channel (in_valid_i / in_stall_o), one
// transaction per point; last_cand_i closes a run. The configuration channel
// (cfg_valid_i / cfg_ready_o) writes the reference coordinates by index and
// is always ready; write it only while the block is idle.
// Each candidate is squared axis by axis through one shared squaring unit:
// the block stalls its input after each accepted transaction that does not
// close a run until that candidate has been compared with the best so far.
// On the last candidate of a run a one-bit-per-cycle square root unit runs
// 31 steps, and the result then appears on the output channel (out_valid_o /
// out_stall_i); the input stays stalled until the result is loaded into
// the output register. The result sits in that register: while the receiver
// stalls it, the block keeps taking candidates of the next run and waits
// only if that run also finishes before the result is taken.
// Reset clears the reference point to zero, forgets any partial run and
// drops a pending result.
// ----------------------------------------------------------------------------
module nearest_point_search_3d (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [nps3d_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [nps3d_pkg::COORD_WIDTH-1:0]        cfg_data_i,
  // candidates
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [nps3d_pkg::COORD_WIDTH-1:0] cand_lat_i,
  input  logic signed [nps3d_pkg::COORD_WIDTH-1:0] cand_lon_i,
  input  logic signed [nps3d_pkg::COORD_WIDTH-1:0] cand_alt_i,
  input  logic [nps3d_pkg::ID_WIDTH-1:0]           cand_id_i,
  input  logic                                     last_cand_i,
  // result
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [nps3d_pkg::ID_WIDTH-1:0]           nearest_id_o,
  output logic [nps3d_pkg::DIST_WIDTH-1:0]         nearest_dist_o
);

  nps3d_pkg::state_e state_q, state_d;

  logic signed [nps3d_pkg::COORD_WIDTH-1:0] ref_lat_q, ref_lon_q, ref_alt_q;
  logic signed [nps3d_pkg::COORD_WIDTH-1:0] cand_lat_q, cand_lon_q, cand_alt_q;
  logic [nps3d_pkg::ID_WIDTH-1:0]           cand_id_q;
  logic                                     cand_last_q;

  logic [nps3d_pkg::AXIS_W-1:0]   issue_cnt_q;
  logic [nps3d_pkg::AXIS_W-1:0]   got_cnt_q;
  logic [nps3d_pkg::SQ_WIDTH-1:0] acc_q;
  logic [nps3d_pkg::SQ_WIDTH-1:0] best_q;
  logic [nps3d_pkg::ID_WIDTH-1:0] best_id_q;
  logic                           started_q;

  logic                             out_valid_q;
  logic [nps3d_pkg::ID_WIDTH-1:0]   out_id_q;
  logic [nps3d_pkg::DIST_WIDTH-1:0] out_dist_q;

  logic in_accept;
  logic issue;
  logic take_best;
  logic root_start;
  logic out_load;

  logic signed [nps3d_pkg::COORD_WIDTH-1:0] sq_a, sq_b;
  logic                                     prod_valid;
  logic [nps3d_pkg::PROD_WIDTH-1:0]         prod;
  logic                                     root_done;
  logic [nps3d_pkg::ROOT_WIDTH-1:0]         root;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign take_best   = !started_q || (acc_q < best_q);

  // Operand select for the shared squaring unit.
  always_comb begin
    case (issue_cnt_q)
      nps3d_pkg::AXIS_LAT: begin
        sq_a = ref_lat_q;
        sq_b = cand_lat_q;
      end
      nps3d_pkg::AXIS_LON: begin
        sq_a = ref_lon_q;
        sq_b = cand_lon_q;
      end
      nps3d_pkg::AXIS_ALT: begin
        sq_a = ref_alt_q;
        sq_b = cand_alt_q;
      end
      default: begin
        sq_a = ref_alt_q;
        sq_b = cand_alt_q;
      end
    endcase
  end

  nps3d_sq_unit u_sq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .a_i          (sq_a),
    .b_i          (sq_b),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  nps3d_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (best_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      nps3d_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = nps3d_pkg::ST_CALC;
        end
      end
      nps3d_pkg::ST_CALC: begin
        issue = (issue_cnt_q != nps3d_pkg::AXIS_W'(nps3d_pkg::NUM_AXES));
        if (prod_valid && (got_cnt_q == nps3d_pkg::AXIS_W'(nps3d_pkg::NUM_AXES - 1))) begin
          state_d = nps3d_pkg::ST_CMP;
        end
      end
      nps3d_pkg::ST_CMP: begin
        if (cand_last_q) begin
          state_d = nps3d_pkg::ST_ROOT;
        end else begin
          state_d = nps3d_pkg::ST_IDLE;
        end
      end
      nps3d_pkg::ST_ROOT: begin
        if (root_done) begin
          state_d = nps3d_pkg::ST_DONE;
        end
      end
      nps3d_pkg::ST_DONE: begin
        // Wait here only while an earlier result is still held.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = nps3d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nps3d_pkg::ST_IDLE;
      end
    endcase
    // The root starts in ST_ROOT, after the best distance has settled.
    if (state_q == nps3d_pkg::ST_CMP && cand_last_q) begin
      state_d = nps3d_pkg::ST_ROOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nps3d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The root unit is started from the first cycle of ST_ROOT.
  logic root_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_pending_q <= 1'b0;
    end else begin
      root_pending_q <= (state_q == nps3d_pkg::ST_CMP) && cand_last_q;
    end
  end

  assign root_start = root_pending_q;

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q   <= '0;
      ref_lon_q   <= '0;
      ref_alt_q   <= '0;
      issue_cnt_q <= '0;
      got_cnt_q   <= '0;
      best_q      <= '0;
      best_id_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nps3d_pkg::REG_REF_LAT: ref_lat_q <= cfg_data_i;
          nps3d_pkg::REG_REF_LON: ref_lon_q <= cfg_data_i;
          nps3d_pkg::REG_REF_ALT: ref_alt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        issue_cnt_q <= '0;
        got_cnt_q   <= '0;
      end else begin
        if (issue) begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
        end
        if (prod_valid) begin
          got_cnt_q <= got_cnt_q + 1'b1;
        end
      end
      if (state_q == nps3d_pkg::ST_CMP) begin
        if (take_best) begin
          best_q    <= acc_q;
          best_id_q <= cand_id_q;
        end
        started_q <= !cand_last_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cand_lat_q  <= cand_lat_i;
      cand_lon_q  <= cand_lon_i;
      cand_alt_q  <= cand_alt_i;
      cand_id_q   <= cand_id_i;
      cand_last_q <= last_cand_i;
      acc_q       <= '0;
    end else if (prod_valid) begin
      acc_q <= acc_q + nps3d_pkg::SQ_WIDTH'(prod);
    end
    if (out_load) begin
      out_id_q   <= best_id_q;
      out_dist_q <= nps3d_pkg::DIST_WIDTH'(root);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign nearest_id_o   = out_id_q;
  assign nearest_dist_o = out_dist_q;

endmodule
